FILE: src/assert_macros.svh
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// Check a property at every rising clock edge outside reset.
`define ASSERT_AT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed: label");
// Check that post holds in the cycle after pre.
`define ASSERT_NEXT(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("assertion failed: label");
`else
`define ASSERT_AT(label, clk, rst, prop)
`define ASSERT_NEXT(label, clk, rst, pre, post)
`endif

`endif

FILE: src/tam_pkg.sv
`timescale 1ns / 1ps
package tam_pkg;

  localparam int NUM_SLOTS = 5;

  // Alert levels
  localparam logic [2:0] LVL_MEDIUM   = 3'd2;
  localparam logic [2:0] LVL_HIGH     = 3'd3;
  localparam logic [2:0] LVL_CRITICAL = 3'd4;

  // Alert categories
  localparam logic [2:0] CAT_EXFIL     = 3'd0;
  localparam logic [2:0] CAT_BANDWIDTH = 3'd1;
  localparam logic [2:0] CAT_CHURN     = 3'd2;
  localparam logic [2:0] CAT_FANOUT    = 3'd3;
  localparam logic [2:0] CAT_EXPOSURE  = 3'd4;
  localparam logic [2:0] CAT_SUSPORT   = 3'd5;

  // Register indexes
  localparam logic [2:0] REG_UPLOAD_SPIKE   = 3'd0;
  localparam logic [2:0] REG_DOWNLOAD_SPIKE = 3'd1;
  localparam logic [2:0] REG_SUSTAINED_RATE = 3'd2;
  localparam logic [2:0] REG_SUSTAINED_HOLD = 3'd3;
  localparam logic [2:0] REG_CHURN_LIMIT    = 3'd4;
  localparam logic [2:0] REG_FANOUT_LIMIT   = 3'd5;

  // Result slots, in output order. Records reuse the first two slots.
  localparam int SLOT_UP_SPIKE   = 0;
  localparam int SLOT_DOWN_SPIKE = 1;
  localparam int SLOT_SUSTAINED  = 2;
  localparam int SLOT_CHURN      = 3;
  localparam int SLOT_FANOUT     = 4;
  localparam int SLOT_EXPOSURE   = 0;
  localparam int SLOT_SUSPORT    = 1;

  localparam logic OP_SNAPSHOT = 1'b0;

  localparam logic [15:0] RISKY_PORTS [9] = '{
    16'd23, 16'd135, 16'd139, 16'd445, 16'd3389, 16'd5900, 16'd6379, 16'd27017, 16'd11211
  };

  localparam logic [15:0] SUSPECT_PORTS [13] = '{
    16'd4444, 16'd5555, 16'd6666, 16'd6667, 16'd31337, 16'd12345, 16'd27374,
    16'd65535, 16'd1337, 16'd4443, 16'd8081, 16'd9050, 16'd9051
  };

  typedef struct packed {
    logic [47:0] upload_spike_rate;
    logic [47:0] download_spike_rate;
    logic [47:0] sustained_upload_rate;
    logic [15:0] sustained_hold_seconds;
    logic [15:0] churn_limit;
    logic [15:0] fanout_limit;
  } cfg_t;

  typedef struct packed {
    logic        opcode;
    logic [47:0] upload_rate;
    logic [47:0] download_rate;
    logic [15:0] established_count;
    logic [15:0] unique_remote_count;
    logic [31:0] now_seconds;
    logic        is_listening;
    logic [15:0] host_port;
    logic [15:0] peer_port;
  } item_t;

  typedef struct packed {
    logic [2:0]  level;
    logic [2:0]  category;
    logic [47:0] value;
  } alert_t;

  typedef struct packed {
    logic [NUM_SLOTS-1:0] mask;
    alert_t [NUM_SLOTS-1:0] slot;
  } batch_t;

  function automatic logic is_risky_port(logic [15:0] port);
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < 9; i++) hit = hit | (port == RISKY_PORTS[i]);
    return hit;
  endfunction

  function automatic logic is_suspect_port(logic [15:0] port);
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < 13; i++) hit = hit | (port == SUSPECT_PORTS[i]);
    return hit;
  endfunction

endpackage

FILE: src/traffic_alert_monitor_top.sv
`timescale 1ns / 1ps
// Channel  Dir  Beat fields
// s_*      in   tuser: opcode; tdata: snapshot rates, counts, time; record flag, ports
// m_*      out  tdata: alert level, category, value; tlast: last alert of the item
// cfg_*    in   cfg_index selects a threshold register, cfg_data carries its value
//
// An accepted item sits in the input register, where its alerts are
// worked out in one pass and handed to the alert register as a batch.
// Items stream one per cycle while each raises at most one alert and
// m_tready holds high; an item with n alerts holds the single alert output
// for n beats, so the input stalls until its last beat is taken. Items with no alert emit nothing.
// Reset (rst, synchronous) clears thresholds, history, and all valid state.
// A stall on m_tready holds the current beat and backs up to s_tready.
module traffic_alert_monitor_top (
  input  logic         clk,
  input  logic         rst,
  // input beats
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [199:0] s_tdata,   // upload_rate[47:0], download_rate[95:48],
                                  // established_count[111:96],
                                  // unique_remote_count[127:112], now_seconds[159:128],
                                  // is_listening[160], host port[176:161],
                                  // peer port[192:177], zero fill above
  input  logic         s_tuser,   // opcode
  // alert beats
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [55:0]  m_tdata,   // alert_level[2:0], alert_category[5:3],
                                  // alert_value[53:6], zero fill above
  output logic         m_tlast,   // last_alert
  // threshold writes
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [47:0]  cfg_data
);

  tam_pkg::cfg_t   cfg;
  tam_pkg::item_t  item;
  tam_pkg::batch_t batch;
  logic            item_valid;
  logic            can_load;
  logic            advance;

  // Move the staged item on once the alert register can take its batch.
  assign advance  = item_valid && can_load;
  assign s_tready = !item_valid || can_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (s_tready) begin
      item_valid <= s_tvalid;
    end
  end

  // Capture the payload on each accepted beat; no reset needed.
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      item.opcode              <= s_tuser;
      item.upload_rate         <= s_tdata[47:0];
      item.download_rate       <= s_tdata[95:48];
      item.established_count   <= s_tdata[111:96];
      item.unique_remote_count <= s_tdata[127:112];
      item.now_seconds         <= s_tdata[159:128];
      item.is_listening        <= s_tdata[160];
      item.host_port           <= s_tdata[176:161];
      item.peer_port           <= s_tdata[192:177];
    end
  end

  tam_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  tam_eval u_eval (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .item    (item),
    .cfg     (cfg),
    .batch   (batch)
  );

  tam_out u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (advance),
    .batch    (batch),
    .can_load (can_load),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

FILE: src/tam_cfg.sv
`timescale 1ns / 1ps
module tam_cfg (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [47:0]         cfg_data,
  output tam_pkg::cfg_t       cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        tam_pkg::REG_UPLOAD_SPIKE:   cfg.upload_spike_rate      <= cfg_data;
        tam_pkg::REG_DOWNLOAD_SPIKE: cfg.download_spike_rate    <= cfg_data;
        tam_pkg::REG_SUSTAINED_RATE: cfg.sustained_upload_rate  <= cfg_data;
        tam_pkg::REG_SUSTAINED_HOLD: cfg.sustained_hold_seconds <= cfg_data[15:0];
        tam_pkg::REG_CHURN_LIMIT:    cfg.churn_limit            <= cfg_data[15:0];
        tam_pkg::REG_FANOUT_LIMIT:   cfg.fanout_limit           <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

endmodule

FILE: src/tam_eval.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module tam_eval (
  input  logic            clk,
  input  logic            rst,
  input  logic            advance,
  input  tam_pkg::item_t  item,
  input  tam_pkg::cfg_t   cfg,
  output tam_pkg::batch_t batch
);

  logic        upload_high_flag;
  logic [31:0] upload_high_start;
  logic [15:0] previous_established;

  logic        snap;
  logic        up_high;
  logic [31:0] held;
  logic [15:0] delta;

  assign snap    = (item.opcode == tam_pkg::OP_SNAPSHOT);
  assign up_high = (item.upload_rate >= cfg.sustained_upload_rate);
  assign held    = item.now_seconds - upload_high_start;
  assign delta   = (item.established_count > previous_established) ?
                   (item.established_count - previous_established) : 16'd0;

  always_comb begin
    batch = '0;
    if (snap) begin
      batch.mask[tam_pkg::SLOT_UP_SPIKE] = (item.upload_rate >= cfg.upload_spike_rate);
      batch.slot[tam_pkg::SLOT_UP_SPIKE] =
        '{tam_pkg::LVL_HIGH, tam_pkg::CAT_EXFIL, item.upload_rate};
      batch.mask[tam_pkg::SLOT_DOWN_SPIKE] =
        (item.download_rate >= cfg.download_spike_rate);
      batch.slot[tam_pkg::SLOT_DOWN_SPIKE] =
        '{tam_pkg::LVL_MEDIUM, tam_pkg::CAT_BANDWIDTH, item.download_rate};
      batch.mask[tam_pkg::SLOT_SUSTAINED] = up_high && upload_high_flag &&
        (held >= {16'd0, cfg.sustained_hold_seconds});
      batch.slot[tam_pkg::SLOT_SUSTAINED] =
        '{tam_pkg::LVL_CRITICAL, tam_pkg::CAT_EXFIL, {16'd0, held}};
      batch.mask[tam_pkg::SLOT_CHURN] = (previous_established != 16'd0) &&
        (delta >= cfg.churn_limit);
      batch.slot[tam_pkg::SLOT_CHURN] =
        '{tam_pkg::LVL_MEDIUM, tam_pkg::CAT_CHURN, {32'd0, delta}};
      batch.mask[tam_pkg::SLOT_FANOUT] = (item.unique_remote_count >= cfg.fanout_limit);
      batch.slot[tam_pkg::SLOT_FANOUT] =
        '{tam_pkg::LVL_MEDIUM, tam_pkg::CAT_FANOUT, {32'd0, item.unique_remote_count}};
    end else begin
      batch.mask[tam_pkg::SLOT_EXPOSURE] = item.is_listening &&
        tam_pkg::is_risky_port(item.host_port);
      batch.slot[tam_pkg::SLOT_EXPOSURE] =
        '{tam_pkg::LVL_HIGH, tam_pkg::CAT_EXPOSURE, {32'd0, item.host_port}};
      batch.mask[tam_pkg::SLOT_SUSPORT] = (item.peer_port != 16'd0) &&
        tam_pkg::is_suspect_port(item.peer_port);
      batch.slot[tam_pkg::SLOT_SUSPORT] =
        '{tam_pkg::LVL_HIGH, tam_pkg::CAT_SUSPORT, {32'd0, item.peer_port}};
    end
  end

  // Advance the history only when the snapshot is handed to the output.
  always_ff @(posedge clk) begin
    if (rst) begin
      upload_high_flag     <= 1'b0;
      upload_high_start    <= '0;
      previous_established <= '0;
    end else if (advance && snap) begin
      upload_high_flag     <= up_high;
      if (up_high && !upload_high_flag) upload_high_start <= item.now_seconds;
      previous_established <= item.established_count;
    end
  end

  `ASSERT_AT(a_sustained_needs_flag, clk, rst,
             !(snap && batch.mask[tam_pkg::SLOT_SUSTAINED]) || upload_high_flag)

endmodule

FILE: src/tam_out.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module tam_out (
  input  logic            clk,
  input  logic            rst,
  input  logic            load,
  input  tam_pkg::batch_t batch,
  output logic            can_load,
  output logic            m_tvalid,
  input  logic            m_tready,
  output logic [55:0]     m_tdata,  // alert_level[2:0], alert_category[5:3], alert_value[53:6]
  output logic            m_tlast   // last_alert
);

  localparam logic [tam_pkg::NUM_SLOTS-1:0] SLOT_ONE = {{(tam_pkg::NUM_SLOTS-1){1'b0}}, 1'b1};

  logic [tam_pkg::NUM_SLOTS-1:0] pending;
  tam_pkg::alert_t [tam_pkg::NUM_SLOTS-1:0] slots;

  logic [tam_pkg::NUM_SLOTS-1:0] sel;
  logic                          one_left;
  tam_pkg::alert_t               cur;

  assign sel      = pending & (~pending + SLOT_ONE);
  assign one_left = ((pending & (pending - SLOT_ONE)) == '0);
  assign m_tvalid = (pending != '0);
  assign m_tlast  = m_tvalid && one_left;
  assign can_load = !m_tvalid || (one_left && m_tready);

  always_comb begin
    cur = '0;
    for (int i = 0; i < tam_pkg::NUM_SLOTS; i++) begin
      if (sel[i]) cur = cur | slots[i];
    end
  end

  assign m_tdata = {2'b00, cur.value, cur.category, cur.level};

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else if (load) begin
      pending <= batch.mask;
    end else if (m_tvalid && m_tready) begin
      pending <= pending & ~sel;
    end
  end

  always_ff @(posedge clk) begin
    if (load) slots <= batch.slot;
  end

  `ASSERT_AT(a_load_only_when_drained, clk, rst, !load || ($countones(pending) <= 1))
  `ASSERT_NEXT(a_last_beat_empties, clk, rst, m_tvalid && m_tready && m_tlast && !load,
               !m_tvalid)
  `ASSERT_NEXT(a_no_new_bits, clk, rst, !load, (pending & ~$past(pending)) == '0)

endmodule
